### rtl/tcp_ct_pkg.sv
// Package: constants, types and command/status structs for the TCP connection table.
package tcp_ct_pkg;
  localparam int SOCKETS = 4;
  localparam int SW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;

  localparam logic [3:0] PH_CLOSED    = 4'd0;
  localparam logic [3:0] PH_SYNRCV    = 4'd1;
  localparam logic [3:0] PH_ESTAB     = 4'd2;
  localparam logic [3:0] PH_CLOSEWAIT = 4'd3;
  localparam logic [3:0] PH_LASTACK   = 4'd4;
  localparam logic [3:0] PH_FINWAIT1  = 4'd5;
  localparam logic [3:0] PH_FINWAIT2  = 4'd6;
  localparam logic [3:0] PH_CLOSING   = 4'd7;
  localparam logic [3:0] PH_TIMEDWAIT = 4'd8;

  localparam logic [5:0] F_FIN = 6'h01;
  localparam logic [5:0] F_SYN = 6'h02;
  localparam logic [5:0] F_RST = 6'h04;
  localparam logic [5:0] F_PSH = 6'h08;
  localparam logic [5:0] F_ACK = 6'h10;

  localparam logic [15:0] ALT_PORT      = 16'd3333;
  localparam logic [7:0]  TIMEDWAIT_TTL = 8'd5;
  localparam logic [17:0] ETH_HDR       = 18'd14;

  localparam logic [1:0] RK_IGNORED = 2'd0;
  localparam logic [1:0] RK_HANDLED = 2'd1;
  localparam logic [1:0] RK_SEND    = 2'd2;
  localparam logic [1:0] RK_TICK    = 2'd3;

  localparam logic [1:0] REG_LOCAL_IP  = 2'd0;
  localparam logic [1:0] REG_TTL       = 2'd1;
  localparam logic [1:0] REG_SERVICE   = 2'd2;
  localparam logic [1:0] REG_BUFFER    = 2'd3;

  typedef struct packed {
    logic [0:0]  action;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  flags;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  header_lengths;
    logic [15:0] ip_total_len;
    logic [1:0]  app_response;
    logic [15:0] app_tx_count;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  socket_index;
    logic [5:0]  send_flags;
    logic [31:0] send_seq;
    logic [31:0] send_ack;
    logic [15:0] send_len;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic [15:0] local_port;
    logic [15:0] payload_start;
    logic [15:0] payload_len;
    logic [3:0]  closed_mask;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic scan;       // examine entry at scan index
    logic [SW-1:0] idx;
    logic tick_step;  // age entry idx
    logic trim;       // compute payload window of selected entry
    logic exec;       // run state machine on selected entry, build result
    logic finish;     // build ignored or tick result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic for_us;
    logic hit;
    logic free_ok;
  } stat_t;
endpackage

### rtl/tcp_ct_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
interface tcp_ct_item_if import tcp_ct_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcp_ct_result_if import tcp_ct_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcp_ct_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] value;
  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface

### rtl/tcp_ct_ctrl.sv
// Controller: sequences load, socket scan, payload trim, execution and result.
module tcp_ct_ctrl import tcp_ct_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TRIM = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state, state_next;
  logic [SW-1:0] idx, idx_next;
  logic          last;

  assign last = (idx == SW'(SOCKETS - 1));
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Step through the scan one entry per cycle
  always_comb begin
    state_next = state;
    idx_next = idx;
    cmd = '0;
    cmd.idx = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
          idx_next = '0;
        end
      end
      S_SCAN: begin
        if (stat.is_tick) begin
          cmd.tick_step = 1'b1;
          idx_next = idx + SW'(1);
          if (last) state_next = S_DONE;
        end else if (!stat.for_us) begin
          state_next = S_DONE;
        end else begin
          cmd.scan = 1'b1;
          idx_next = idx + SW'(1);
          if (last) state_next = S_TRIM;
        end
      end
      S_TRIM: begin
        if (stat.hit) begin
          cmd.trim = 1'b1;
          state_next = S_EXEC;
        end else if (stat.free_ok) begin
          state_next = S_EXEC;
        end else begin
          state_next = S_DONE;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_OUT;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
  end
endmodule

### rtl/tcp_ct_dp.sv
// Datapath: socket table, matching, payload trimming and per-socket state update.
module tcp_ct_dp import tcp_ct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [31:0] local_ip,
  input  logic [7:0]  ttl_reload,
  input  logic [15:0] service_port,
  input  logic [15:0] buffer_size,
  output result_t     result
);
  logic [3:0]  phase [SOCKETS];
  logic [31:0] paddr [SOCKETS];
  logic [15:0] pport [SOCKETS];
  logic [15:0] oport [SOCKETS];
  logic [31:0] sseq  [SOCKETS];
  logic [31:0] rexp  [SOCKETS];
  logic [7:0]  ttl   [SOCKETS];

  item_t         it;
  logic          hit, fr_found, tw_found;
  logic [SW-1:0] hit_idx, fr_idx, tw_idx, sel;
  logic [3:0]    mask;
  logic [17:0]   tpos;
  logic [17:0]   tlen;
  logic          tahead;

  assign stat.is_tick = it.action[0];
  assign stat.for_us  = (it.dst_ip == local_ip);
  assign stat.hit     = hit;
  assign stat.free_ok = (it.flags == F_SYN) && (fr_found || tw_found);
  assign sel = hit ? hit_idx : (fr_found ? fr_idx : tw_idx);

  // Payload window before sequence trimming
  logic [17:0] pos0, len0, ih, th, tot;
  logic [31:0] sel_exp, gap;
  logic [33:0] d_pos, d_len;
  assign ih  = {12'd0, it.header_lengths[3:0], 2'b00};
  assign th  = {12'd0, it.header_lengths[7:4], 2'b00};
  assign tot = {2'd0, it.ip_total_len};
  assign pos0 = ETH_HDR + ih + th;
  assign len0 = tot - ih - th;
  assign sel_exp = rexp[sel];
  assign gap = sel_exp - it.seq_num;

  // Trim old data and clamp to buffer, signed arithmetic on 34 bits
  logic signed [33:0] sp, sl, bs;
  always_comb begin
    sp = {16'd0, pos0};
    sl = {{16{len0[17]}}, len0};
    bs = {18'd0, buffer_size};
    if (it.seq_num != sel_exp && sel_exp != 32'd0 && it.seq_num < sel_exp) begin
      sp = sp + {2'd0, gap};
      sl = sl - {2'd0, gap};
    end
    if (sp > bs) sp = bs;
    if (sl < 0 || sp + sl > bs) sl = '0;
    d_pos = sp;
    d_len = sl;
  end

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      tpos <= d_pos[17:0];
      tlen <= d_len[17:0];
      tahead <= (it.seq_num != sel_exp) && (sel_exp != 32'd0) && !(it.seq_num < sel_exp);
    end
  end

  // Capture item, scan entries, and execute
  always_ff @(posedge clk) begin
    logic [3:0]  ph;
    logic [5:0]  fl;
    logic [31:0] ss;
    logic [31:0] re;
    logic [7:0]  tt;
    result_t     r;
    if (rst) begin
      for (int i = 0; i < SOCKETS; i++) phase[i] <= PH_CLOSED;
      hit <= 1'b0;
      fr_found <= 1'b0;
      tw_found <= 1'b0;
      mask <= '0;
    end else begin
      if (cmd.load) begin
        it <= item;
        hit <= 1'b0;
        fr_found <= 1'b0;
        tw_found <= 1'b0;
        mask <= '0;
        hit_idx <= '0;
        fr_idx <= '0;
        tw_idx <= '0;
      end
      if (cmd.scan) begin
        if (!hit && phase[cmd.idx] != PH_CLOSED && pport[cmd.idx] == it.src_port &&
            paddr[cmd.idx] == it.src_ip) begin
          hit <= 1'b1;
          hit_idx <= cmd.idx;
        end
        if (!fr_found && phase[cmd.idx] == PH_CLOSED) begin
          fr_found <= 1'b1;
          fr_idx <= cmd.idx;
        end
        if (!tw_found && phase[cmd.idx] == PH_TIMEDWAIT) begin
          tw_found <= 1'b1;
          tw_idx <= cmd.idx;
        end
      end
      if (cmd.tick_step && phase[cmd.idx] != PH_CLOSED) begin
        tt = ttl[cmd.idx] - 8'd1;
        ttl[cmd.idx] <= tt;
        if (tt == 8'd0) begin
          phase[cmd.idx] <= PH_CLOSED;
          mask[2'(cmd.idx)] <= 1'b1;
        end
      end
      if (cmd.finish) begin
        r = '0;
        if (it.action[0]) begin
          r.result_kind = RK_TICK;
          r.closed_mask = mask;
        end
        result <= r;
      end
      if (cmd.exec) begin
        fl = it.flags;
        ph = phase[sel];
        ss = sseq[sel];
        re = rexp[sel];
        r = '0;
        r.socket_index = 2'(sel);
        r.remote_ip = paddr[sel];
        r.remote_port = pport[sel];
        r.local_port = oport[sel];
        r.send_seq = sseq[sel];
        r.send_ack = rexp[sel];
        r.result_kind = RK_HANDLED;
        if (!hit) begin
          // New connection from a bare SYN
          ph = PH_SYNRCV;
          pport[sel] <= it.src_port;
          paddr[sel] <= it.src_ip;
          oport[sel] <= it.dst_port;
          re = it.seq_num + 32'd1;
          ss = 32'd1;
          r.result_kind = RK_SEND;
          r.send_flags = F_SYN | F_ACK;
          r.send_seq = 32'd0;
          r.send_ack = it.seq_num + 32'd1;
          r.remote_ip = it.src_ip;
          r.remote_port = it.src_port;
          r.local_port = it.dst_port;
        end else begin
          if ((fl & F_RST) != 0) begin
            ph = PH_CLOSED;
          end else begin
            unique case (ph)
              PH_SYNRCV: ph = (fl == F_ACK) ? PH_ESTAB : PH_CLOSED;
              PH_ESTAB: begin
                if ((fl & F_FIN) != 0) begin
                  ph = PH_LASTACK;
                  re = it.seq_num + 32'd1;
                  ss = it.ack_num;
                  r.result_kind = RK_SEND;
                  r.send_flags = F_FIN | F_ACK;
                  r.send_seq = it.ack_num;
                  r.send_ack = it.seq_num + 32'd1;
                end else begin
                  if (it.ack_num != ss && it.ack_num != 32'd1) ss = it.ack_num;
                  r.send_seq = ss;
                  if (tahead) begin
                    r.result_kind = RK_SEND;
                    r.send_flags = F_ACK;
                  end else begin
                    re = sel_exp + {14'd0, tlen};
                    r.send_ack = re;
                    r.payload_start = tpos[15:0];
                    r.payload_len = tlen[15:0];
                    if (oport[sel] == service_port || oport[sel] == ALT_PORT) begin
                      case (it.app_response)
                        2'd1: begin
                          r.result_kind = RK_SEND;
                          r.send_flags = F_ACK;
                        end
                        2'd2: begin
                          r.result_kind = RK_SEND;
                          r.send_flags = F_ACK;
                          r.send_len = it.app_tx_count;
                          ss = ss + {16'd0, it.app_tx_count};
                        end
                        2'd3: begin
                          ph = PH_FINWAIT1;
                          r.result_kind = RK_SEND;
                          r.send_flags = F_FIN | F_PSH | F_ACK;
                          ss = ss + 32'd1;
                        end
                        default: ;
                      endcase
                    end
                  end
                end
              end
              PH_CLOSEWAIT: begin
                ph = PH_LASTACK;
                re = it.seq_num + 32'd1;
                ss = it.ack_num;
                r.result_kind = RK_SEND;
                r.send_flags = F_FIN;
                r.send_seq = it.ack_num;
                r.send_ack = it.seq_num + 32'd1;
              end
              PH_LASTACK: ph = PH_CLOSED;
              PH_FINWAIT1: begin
                re = it.seq_num + 32'd1;
                r.send_ack = it.seq_num + 32'd1;
                if (fl == F_FIN) begin
                  ph = PH_CLOSING;
                  r.result_kind = RK_SEND;
                  r.send_flags = F_ACK;
                end else if (fl == (F_FIN | F_ACK)) begin
                  ph = (it.ack_num == sseq[sel]) ? PH_CLOSED : PH_LASTACK;
                  r.result_kind = RK_SEND;
                  r.send_flags = F_ACK;
                end else begin
                  ph = PH_FINWAIT2;
                end
              end
              PH_FINWAIT2: begin
                re = it.seq_num + 32'd1;
                if ((fl & F_FIN) != 0) begin
                  ph = PH_TIMEDWAIT;
                  r.result_kind = RK_SEND;
                  r.send_flags = F_ACK;
                  r.send_ack = it.seq_num + 32'd1;
                end
              end
              PH_TIMEDWAIT: ;
              PH_CLOSING: if ((fl & F_ACK) != 0) ph = PH_TIMEDWAIT;
              default: ph = PH_CLOSED;
            endcase
          end
        end
        // Drop the outgoing segment fields when nothing is sent
        if (r.result_kind != RK_SEND) begin
          r.send_flags = '0;
          r.send_seq = '0;
          r.send_ack = '0;
          r.send_len = '0;
          r.remote_ip = '0;
          r.remote_port = '0;
          r.local_port = '0;
        end
        phase[sel] <= ph;
        sseq[sel] <= ss;
        rexp[sel] <= re;
        ttl[sel] <= (ph == PH_TIMEDWAIT) ? TIMEDWAIT_TTL : ttl_reload;
        result <= r;
      end
    end
  end
endmodule

### rtl/tcp_connection_table_unit.sv
// Top level: configuration registers, controller and datapath of the TCP connection table.
//
// Usage: items enter on in_ch (valid/ready). Each item is a parsed TCP
// segment or a one-second tick; every item gives exactly one result on
// out_ch, which holds until the receiver takes it. Registers are written on
// cfg_ch (index 0 local_ip, 1 ttl_reload, 2 service_port, 3 buffer_size);
// write them only while the block is idle.
// A tick result follows a scan that ages the table one entry per cycle.
// For a segment for our address, the controller scans the table one entry
// per cycle, trims the payload window, then updates the matched or a free
// entry, if any. A segment for another address goes straight to its result.
// Throughput: one item at a time; the next item is taken the cycle after
// the result transfer.
// Reset closes all sockets and loads the register defaults. A stalled
// receiver holds the result and the block takes no new item.
module tcp_connection_table_unit import tcp_ct_pkg::*; (
  input logic clk,
  input logic rst,
  tcp_ct_item_if.sink     in_ch,
  tcp_ct_result_if.source out_ch,
  tcp_ct_cfg_if.sink      cfg_ch
);
  logic [31:0] local_ip;
  logic [7:0]  ttl_reload;
  logic [15:0] service_port;
  logic [15:0] buffer_size;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= 32'd0;
      ttl_reload <= 8'd30;
      service_port <= 16'd80;
      buffer_size <= 16'd1536;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_LOCAL_IP: local_ip <= cfg_ch.value;
        REG_TTL:      ttl_reload <= cfg_ch.value[7:0];
        REG_SERVICE:  service_port <= cfg_ch.value[15:0];
        REG_BUFFER:   buffer_size <= cfg_ch.value[15:0];
        default: ;
      endcase
    end
  end

  tcp_ct_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  tcp_ct_dp u_dp (
    .clk(clk), .rst(rst), .item(in_ch.data), .cmd(cmd), .stat(stat),
    .local_ip(local_ip), .ttl_reload(ttl_reload),
    .service_port(service_port), .buffer_size(buffer_size),
    .result(out_ch.data)
  );
endmodule

### tb/sv/tcp_ct_checker.sv
// Checker: watches the item and result channels, predicts each result and compares.
module tcp_ct_checker import tcp_ct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  item_t       in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_value,
  output int          fail_count,
  output int          pending
);
  // register copies
  logic [31:0] our_ip;
  logic [7:0]  ttl_load;
  logic [15:0] app_port;
  logic [15:0] buf_bytes;

  // table copy
  logic [3:0]  phase   [SOCKETS];
  logic [31:0] peer_ip [SOCKETS];
  logic [15:0] peer_pt [SOCKETS];
  logic [15:0] own_pt  [SOCKETS];
  logic [31:0] snd_seq [SOCKETS];
  logic [31:0] rcv_exp [SOCKETS];
  logic [7:0]  ttl     [SOCKETS];

  result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic result_t segment_out(int s, logic [5:0] fl, logic [15:0] len);
    result_t r;
    r = '0;
    r.result_kind  = RK_SEND;
    r.socket_index = s[1:0];
    r.send_flags   = fl;
    r.send_seq     = snd_seq[s];
    r.send_ack     = rcv_exp[s];
    r.send_len     = len;
    r.remote_ip    = peer_ip[s];
    r.remote_port  = peer_pt[s];
    r.local_port   = own_pt[s];
    return r;
  endfunction

  function automatic result_t handled_out(int s);
    result_t r;
    r = '0;
    r.result_kind  = RK_HANDLED;
    r.socket_index = s[1:0];
    return r;
  endfunction

  // data-phase handling of an established connection
  function automatic result_t run_established(item_t it, int s);
    result_t r;
    longint pos, len, d;
    logic [31:0] exp_seq;
    logic [15:0] start_w, len_w;
    if (it.flags & F_FIN) begin
      phase[s]   = PH_LASTACK;
      rcv_exp[s] = it.seq_num + 32'd1;
      snd_seq[s] = it.ack_num;
      return segment_out(s, F_FIN | F_ACK, 16'd0);
    end
    if (it.ack_num != snd_seq[s] && it.ack_num != 32'd1) snd_seq[s] = it.ack_num;
    pos = 14 + longint'(it.header_lengths[3:0]) * 4 + longint'(it.header_lengths[7:4]) * 4;
    len = longint'(it.ip_total_len) + 14 - pos;
    exp_seq = rcv_exp[s];
    if (it.seq_num != exp_seq && exp_seq != 32'd0) begin
      if (it.seq_num < exp_seq) begin
        d = longint'(exp_seq - it.seq_num);
        pos += d;
        len -= d;
      end else begin
        return segment_out(s, F_ACK, 16'd0);
      end
    end
    if (pos > longint'(buf_bytes)) pos = longint'(buf_bytes);
    if (len < 0 || pos + len > longint'(buf_bytes)) len = 0;
    rcv_exp[s] = exp_seq + 32'(len);
    start_w = pos[15:0];
    len_w   = len[15:0];
    if (own_pt[s] != app_port && own_pt[s] != ALT_PORT) begin
      r = handled_out(s);
    end else begin
      case (it.app_response)
        2'd1: r = segment_out(s, F_ACK, 16'd0);
        2'd2: begin
          r = segment_out(s, F_ACK, it.app_tx_count);
          snd_seq[s] += 32'(it.app_tx_count);
        end
        2'd3: begin
          phase[s] = PH_FINWAIT1;
          r = segment_out(s, F_FIN | F_PSH | F_ACK, 16'd0);
          snd_seq[s] += 32'd1;
        end
        default: r = handled_out(s);
      endcase
    end
    r.payload_start = start_w;
    r.payload_len   = len_w;
    return r;
  endfunction

  // state machine of a matched entry
  function automatic result_t run_entry(item_t it, int s);
    result_t r;
    logic [5:0] fl;
    fl = it.flags;
    ttl[s] = ttl_load;
    if (fl & F_RST) begin
      phase[s] = PH_CLOSED;
      return handled_out(s);
    end
    case (phase[s])
      PH_SYNRCV: begin
        phase[s] = (fl == F_ACK) ? PH_ESTAB : PH_CLOSED;
        r = handled_out(s);
      end
      PH_ESTAB: r = run_established(it, s);
      PH_CLOSEWAIT: begin
        phase[s] = PH_LASTACK;
        rcv_exp[s] = it.seq_num + 32'd1;
        snd_seq[s] = it.ack_num;
        r = segment_out(s, F_FIN, 16'd0);
      end
      PH_LASTACK: begin
        phase[s] = PH_CLOSED;
        r = handled_out(s);
      end
      PH_FINWAIT1: begin
        rcv_exp[s] = it.seq_num + 32'd1;
        if (fl == F_FIN) begin
          phase[s] = PH_CLOSING;
          r = segment_out(s, F_ACK, 16'd0);
        end else if (fl == (F_FIN | F_ACK)) begin
          phase[s] = (it.ack_num == snd_seq[s]) ? PH_CLOSED : PH_LASTACK;
          r = segment_out(s, F_ACK, 16'd0);
        end else begin
          phase[s] = PH_FINWAIT2;
          r = handled_out(s);
        end
      end
      PH_FINWAIT2: begin
        rcv_exp[s] = it.seq_num + 32'd1;
        if (fl & F_FIN) begin
          phase[s] = PH_TIMEDWAIT;
          r = segment_out(s, F_ACK, 16'd0);
        end else begin
          r = handled_out(s);
        end
      end
      PH_TIMEDWAIT: r = handled_out(s);
      PH_CLOSING: begin
        if (fl & F_ACK) phase[s] = PH_TIMEDWAIT;
        r = handled_out(s);
      end
      default: begin
        phase[s] = PH_CLOSED;
        r = handled_out(s);
      end
    endcase
    if (phase[s] == PH_TIMEDWAIT) ttl[s] = TIMEDWAIT_TTL;
    return r;
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    int s;
    r = '0;
    if (it.action) begin
      for (int i = 0; i < SOCKETS; i++) begin
        if (phase[i] != PH_CLOSED) begin
          ttl[i] = ttl[i] - 8'd1;
          if (ttl[i] == 8'd0) begin
            phase[i] = PH_CLOSED;
            r.closed_mask[i] = 1'b1;
          end
        end
      end
      r.result_kind = RK_TICK;
      return r;
    end
    if (it.dst_ip != our_ip) return r;
    for (int i = 0; i < SOCKETS; i++) begin
      if (phase[i] != PH_CLOSED && peer_pt[i] == it.src_port && peer_ip[i] == it.src_ip)
        return run_entry(it, i);
    end
    if (it.flags != F_SYN) return r;
    s = SOCKETS;
    for (int i = 0; i < SOCKETS; i++)
      if (s == SOCKETS && phase[i] == PH_CLOSED) s = i;
    for (int i = 0; i < SOCKETS; i++)
      if (s == SOCKETS && phase[i] == PH_TIMEDWAIT) s = i;
    if (s == SOCKETS) return r;
    phase[s]   = PH_SYNRCV;
    peer_pt[s] = it.src_port;
    peer_ip[s] = it.src_ip;
    own_pt[s]  = it.dst_port;
    rcv_exp[s] = it.seq_num + 32'd1;
    snd_seq[s] = 32'd0;
    ttl[s]     = ttl_load;
    r = segment_out(s, F_SYN | F_ACK, 16'd0);
    snd_seq[s] = 32'd1;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      our_ip = '0;
      ttl_load = 8'd30;
      app_port = 16'd80;
      buf_bytes = 16'd1536;
      for (int i = 0; i < SOCKETS; i++) phase[i] = PH_CLOSED;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOCAL_IP: our_ip    = cfg_value;
          REG_TTL:      ttl_load  = cfg_value[7:0];
          REG_SERVICE:  app_port  = cfg_value[15:0];
          REG_BUFFER:   buf_bytes = cfg_value[15:0];
        endcase
      end
      // predict on input transfer
      if (in_valid && in_ready) expected_results.push_back(predict_result(in_data));
      // compare on output transfer
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          compare_field("result_kind", e.result_kind, out_data.result_kind);
          compare_field("socket_index", e.socket_index, out_data.socket_index);
          compare_field("send_flags", e.send_flags, out_data.send_flags);
          compare_field("send_seq", e.send_seq, out_data.send_seq);
          compare_field("send_ack", e.send_ack, out_data.send_ack);
          compare_field("send_len", e.send_len, out_data.send_len);
          compare_field("remote_ip", e.remote_ip, out_data.remote_ip);
          compare_field("remote_port", e.remote_port, out_data.remote_port);
          compare_field("local_port", e.local_port, out_data.local_port);
          compare_field("payload_start", e.payload_start, out_data.payload_start);
          compare_field("payload_len", e.payload_len, out_data.payload_len);
          compare_field("closed_mask", e.closed_mask, out_data.closed_mask);
        end
      end
    end
  end
endmodule

### tb/sv/tb_tcp_connection_table_unit.sv
// Testbench top: clock, reset, stimulus, register phases and verdict.
module tb_tcp_connection_table_unit;
  import tcp_ct_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   ready_burst = 1'b0;
  bit   quiet_phase = 1'b0;
  bit   hold_off = 1'b0;

  tcp_ct_item_if   in_ch ();
  tcp_ct_result_if out_ch ();
  tcp_ct_cfg_if    cfg_ch ();

  tcp_connection_table_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  tcp_ct_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_index(cfg_ch.index),
    .cfg_value(cfg_ch.value), .fail_count(fail_count), .pending(pending)
  );

  // peers in use by the random part
  logic [31:0] peer_ips   [4];
  logic [15:0] peer_ports [4];
  logic [31:0] peer_seq   [4];
  logic [31:0] our_addr;
  logic [15:0] svc_port;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result receiver: random stalls, stall-free stretches and one long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) out_ch.ready <= 1'b0;
    else if (quiet_phase) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= 34);
  end

  initial begin
    wait (cycle_count == 2000);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_item(item_t it);
    if (!quiet_phase) begin
      while ($urandom_range(99) < 34) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic item_t make_segment(logic [31:0] sip, logic [15:0] sport,
                                         logic [5:0] fl, logic [31:0] sq);
    item_t it;
    it = '0;
    it.src_ip = sip;
    it.dst_ip = our_addr;
    it.src_port = sport;
    it.dst_port = svc_port;
    it.flags = fl;
    it.seq_num = sq;
    it.ack_num = $urandom();
    it.header_lengths = 8'h55;
    it.ip_total_len = 16'd40 + 16'($urandom_range(200));
    it.app_response = 2'($urandom_range(3));
    it.app_tx_count = 16'($urandom_range(1000));
    return it;
  endfunction

  function automatic item_t tick_item();
    item_t it;
    it = '0;
    it.action = 1'b1;
    return it;
  endfunction

  // random noise over all fields
  function automatic item_t noise_item();
    item_t it;
    it.action = 1'($urandom_range(1));
    it.src_ip = $urandom();
    it.dst_ip = ($urandom_range(3) == 0) ? $urandom() : our_addr;
    it.src_port = 16'($urandom());
    it.dst_port = 16'($urandom());
    it.flags = 6'($urandom());
    it.seq_num = $urandom();
    it.ack_num = $urandom();
    it.header_lengths = 8'($urandom());
    it.ip_total_len = 16'($urandom());
    it.app_response = 2'($urandom());
    it.app_tx_count = 16'($urandom());
    return it;
  endfunction

  // one random item from a connection-oriented mix
  task automatic random_item();
    int p, sel;
    item_t it;
    p = $urandom_range(3);
    sel = $urandom_range(99);
    if (sel < 8) begin
      it = tick_item();
    end else if (sel < 16) begin
      it = noise_item();
    end else if (sel < 28) begin
      peer_seq[p] = $urandom();
      it = make_segment(peer_ips[p], peer_ports[p], F_SYN, peer_seq[p]);
      peer_seq[p] += 32'd1;
    end else if (sel < 40) begin
      it = make_segment(peer_ips[p], peer_ports[p], F_ACK, peer_seq[p]);
      it.ack_num = ($urandom_range(1)) ? 32'd1 : $urandom();
    end else if (sel < 80) begin
      it = make_segment(peer_ips[p], peer_ports[p], F_ACK | F_PSH, peer_seq[p]);
      case ($urandom_range(3))
        0: it.seq_num = peer_seq[p] - $urandom_range(30);
        1: it.seq_num = peer_seq[p] + $urandom_range(30);
        default: ;
      endcase
      if ($urandom_range(9) == 0) it.header_lengths = 8'($urandom());
      if ($urandom_range(9) == 0) it.dst_port = ($urandom_range(1)) ? ALT_PORT : 16'($urandom());
      peer_seq[p] += 32'(it.ip_total_len) - 32'd40;
    end else if (sel < 90) begin
      it = make_segment(peer_ips[p], peer_ports[p],
                        ($urandom_range(1)) ? F_FIN | F_ACK : F_FIN, peer_seq[p]);
      peer_seq[p] += 32'd1;
    end else if (sel < 95) begin
      it = make_segment(peer_ips[p], peer_ports[p], 6'($urandom()), peer_seq[p]);
    end else begin
      it = make_segment(peer_ips[p], peer_ports[p], F_RST | F_ACK, peer_seq[p]);
    end
    send_item(it);
  endtask

  task automatic new_peers();
    for (int i = 0; i < 4; i++) begin
      peer_ips[i] = $urandom();
      peer_ports[i] = 16'($urandom());
      peer_seq[i] = $urandom();
    end
  endtask

  // stimulus
  initial begin
    item_t it;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LOCAL_IP;
    cfg_ch.value = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults first, then one register set
    our_addr = 32'd0;
    svc_port = 16'd80;
    new_peers();
    quiet_phase = 1'b1;
    send_item(tick_item());
    send_item(make_segment(peer_ips[0], peer_ports[0], F_ACK, 32'd5));
    it = make_segment(32'hFFFF_FFFF, 16'hFFFF, F_SYN, 32'hFFFF_FFFF);
    send_item(it);
    it = make_segment(32'hFFFF_FFFF, 16'hFFFF, F_ACK, 32'd0);
    send_item(it);
    it = make_segment(32'hFFFF_FFFF, 16'hFFFF, F_ACK | F_PSH, 32'd0);
    it.header_lengths = 8'hFF;
    it.ip_total_len = 16'hFFFF;
    it.app_response = 2'd2;
    it.app_tx_count = 16'hFFFF;
    send_item(it);
    it.seq_num = 32'd100;
    send_item(it);
    it = make_segment(32'hFFFF_FFFF, 16'hFFFF, F_ACK | F_PSH, 32'd50);
    it.header_lengths = 8'h00;
    it.ip_total_len = 16'd0;
    it.app_response = 2'd3;
    send_item(it);
    it = make_segment(32'hFFFF_FFFF, 16'hFFFF, F_FIN | F_ACK, 32'd60);
    send_item(it);
    // fill the table, then age the entries out with ticks
    for (int i = 0; i < 5; i++) begin
      it = make_segment(32'(i), 16'(i), F_SYN, 32'd0);
      send_item(it);
    end
    it = make_segment(32'd1, 16'd1, F_FIN, 32'd7);
    send_item(it);
    send_item(it);
    for (int i = 0; i < 32; i++) send_item(tick_item());
    drain();

    write_reg(REG_LOCAL_IP, 32'hFFFF_FFFF);
    write_reg(REG_TTL, 32'd1);
    write_reg(REG_SERVICE, 32'd65535);
    write_reg(REG_BUFFER, 32'd64);
    our_addr = 32'hFFFF_FFFF;
    svc_port = 16'd65535;
    send_item(make_segment(32'd9, 16'd9, F_SYN, 32'd0));
    send_item(tick_item());
    send_item(make_segment(32'd9, 16'd9, F_RST, 32'd0));
    quiet_phase = 1'b0;
    drain();

    // random phases across register settings
    for (int ph = 0; ph < 5; ph++) begin
      our_addr = (ph == 4) ? 32'd0 : $urandom();
      svc_port = (ph == 1) ? 16'd0 : 16'($urandom());
      write_reg(REG_LOCAL_IP, our_addr);
      write_reg(REG_TTL, (ph == 0) ? 32'd255 : (ph == 1) ? 32'd1 : $urandom_range(2, 40));
      write_reg(REG_SERVICE, {16'd0, svc_port});
      write_reg(REG_BUFFER, (ph == 2) ? 32'd65535 : (ph == 3) ? 32'd64 : $urandom_range(64, 2000));
      new_peers();
      for (int n = 0; n < 350; n++) begin
        quiet_phase = (ph == 2 && n >= 100 && n < 200);
        random_item();
      end
      quiet_phase = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### sim.f
rtl/tcp_ct_pkg.sv
rtl/tcp_ct_if.sv
rtl/tcp_ct_ctrl.sv
rtl/tcp_ct_dp.sv
rtl/tcp_connection_table_unit.sv
tb/sv/tcp_ct_checker.sv
tb/sv/tb_tcp_connection_table_unit.sv
